@@ src/rtu_fte_pkg.sv @@
// rtu_fte_pkg: shared types, codes and defaults of the rtu frame timing engine
// no dependencies; used by rtu_fte_gap_timer and rtu_frame_timing_engine_unit
package rtu_fte_pkg;

  localparam int GAP_W           = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int FRAME_BYTES_DEF = 256;

  localparam logic [GAP_W-1:0] SHORT_GAP_RST = 16'd15;
  localparam logic [GAP_W-1:0] LONG_GAP_RST  = 16'd35;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP  = 1'b1;

  // event command codes
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_RX_BYTE  = 3'd1;
  localparam logic [2:0] CMD_OVERRUN  = 3'd2;
  localparam logic [2:0] CMD_CONSUMED = 3'd3;
  localparam logic [2:0] CMD_REPLY    = 3'd4;
  localparam logic [2:0] CMD_TX_DONE  = 3'd5;

  typedef enum logic [2:0] {
    PH_INIT      = 3'd0,
    PH_IDLE      = 3'd1,
    PH_RECEPTION = 3'd2,
    PH_WAIT      = 3'd3,
    PH_EMISSION  = 3'd4
  } phase_t;

  // what a gap timer does in one cycle
  typedef enum logic [2:0] {
    TMR_HOLD,
    TMR_TICK,
    TMR_RESTART,
    TMR_CLEAR,
    TMR_STOP
  } tmr_op_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] rx_data;
    logic       reply_ok;
  } evt_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       store_en;
    logic [7:0] store_index;
    logic [7:0] store_data;
    logic       frame_ready;
    logic [8:0] frame_length;
    logic       emit_window;
    logic       tx_start;
    logic       overflow_drop;
  } rpt_t;

endpackage

@@ src/rtu_fte_gap_timer.sv @@
// rtu_fte_gap_timer: silence timer with count and enable, fires past its limit
// depends on rtu_fte_pkg
module rtu_fte_gap_timer #(
  parameter logic RST_EN = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rtu_fte_pkg::tmr_op_t          op,
  input  logic [rtu_fte_pkg::GAP_W-1:0] limit,
  output logic                          expire
);

  logic [rtu_fte_pkg::GAP_W-1:0] count;
  logic                          en;
  logic [rtu_fte_pkg::GAP_W:0]   count_inc;

  assign count_inc = {1'b0, count} + 17'd1;
  // a tick now would fire the timer
  assign expire    = en && (count_inc > {1'b0, limit});

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      en    <= RST_EN;
    end else begin
      unique case (op)
        rtu_fte_pkg::TMR_TICK: begin
          if (en) begin
            if (expire) begin
              count <= '0;
              en    <= 1'b0;
            end else begin
              count <= count_inc[rtu_fte_pkg::GAP_W-1:0];
            end
          end
        end
        rtu_fte_pkg::TMR_RESTART: begin
          count <= '0;
          en    <= 1'b1;
        end
        rtu_fte_pkg::TMR_CLEAR: count <= '0;
        rtu_fte_pkg::TMR_STOP: begin
          count <= '0;
          en    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/rtu_frame_timing_engine_unit.sv @@
// rtu_frame_timing_engine_unit: frame delimiting and reply turnaround timing
// depends on rtu_fte_pkg and rtu_fte_gap_timer
//
//  channel  | signals                        | direction | transaction
//  ---------+--------------------------------+-----------+-----------------------------
//  evt      | evt_valid, evt_ready, evt      | in        | one event (tick, byte, ...)
//  rpt      | rpt_valid, rpt_ready, rpt      | out       | one report for each event
//  cfg      | cfg_we, cfg_index, cfg_data    | in        | gap register write
//
// one event per cycle while rpt is not stalled; each event is handled in the cycle
// it is accepted and its report sits in the output register the next cycle
// evt_ready is high while the output register is empty or being drained, so a
// stall on rpt holds back at most one report
// rst is synchronous: phase init, long timer running, gaps 15 and 35 ticks
module rtu_frame_timing_engine_unit #(
  parameter int FRAME_BYTES = rtu_fte_pkg::FRAME_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              evt_valid,
  output logic                              evt_ready,
  input  rtu_fte_pkg::evt_t                 evt,
  output logic                              rpt_valid,
  input  logic                              rpt_ready,
  output rtu_fte_pkg::rpt_t                 rpt,
  input  logic                              cfg_we,
  input  logic [rtu_fte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtu_fte_pkg::GAP_W-1:0]     cfg_data
);

  // byte counter must hold FRAME_BYTES itself
  localparam int              BC_W = $clog2(FRAME_BYTES + 1);
  localparam logic [BC_W-1:0] FULL = BC_W'(FRAME_BYTES);

  logic [rtu_fte_pkg::GAP_W-1:0] short_gap;
  logic [rtu_fte_pkg::GAP_W-1:0] long_gap;

  rtu_fte_pkg::phase_t phase_reg, phase_next, phase_mid;
  logic [BC_W-1:0]     byte_count, byte_count_next;

  rtu_fte_pkg::tmr_op_t short_op, long_op;
  logic                 short_expire, long_expire;

  rtu_fte_pkg::rpt_t rpt_next;
  logic              evt_take;

  assign evt_ready = !rpt_valid || rpt_ready;
  assign evt_take  = evt_valid && evt_ready;

  // gap registers
  always_ff @(posedge clk) begin
    if (rst) begin
      short_gap <= rtu_fte_pkg::SHORT_GAP_RST;
      long_gap  <= rtu_fte_pkg::LONG_GAP_RST;
    end else if (cfg_we) begin
      if (cfg_index == rtu_fte_pkg::CFG_SHORT_GAP) begin
        short_gap <= cfg_data;
      end
      if (cfg_index == rtu_fte_pkg::CFG_LONG_GAP) begin
        long_gap <= cfg_data;
      end
    end
  end

  // t1.5 ends a reception, t3.5 covers start-up, reply window and turnaround
  rtu_fte_gap_timer #(.RST_EN(1'b0)) u_short_timer (
    .clk    (clk),
    .rst    (rst),
    .op     (short_op),
    .limit  (short_gap),
    .expire (short_expire)
  );

  rtu_fte_gap_timer #(.RST_EN(1'b1)) u_long_timer (
    .clk    (clk),
    .rst    (rst),
    .op     (long_op),
    .limit  (long_gap),
    .expire (long_expire)
  );

  // event decode: next phase, byte count, timer actions and report
  always_comb begin
    phase_next      = phase_reg;
    phase_mid       = phase_reg;
    byte_count_next = byte_count;
    short_op        = rtu_fte_pkg::TMR_HOLD;
    long_op         = rtu_fte_pkg::TMR_HOLD;
    rpt_next        = '0;

    if (evt_take) begin
      unique case (evt.cmd)
        rtu_fte_pkg::CMD_TICK: begin
          short_op = rtu_fte_pkg::TMR_TICK;
          long_op  = rtu_fte_pkg::TMR_TICK;
          // short timer first, the long timer then sees its phase
          if (short_expire && phase_reg == rtu_fte_pkg::PH_RECEPTION) begin
            phase_mid            = rtu_fte_pkg::PH_WAIT;
            rpt_next.frame_ready = 1'b1;
          end
          phase_next = phase_mid;
          if (long_expire) begin
            unique case (phase_mid)
              rtu_fte_pkg::PH_INIT: phase_next = rtu_fte_pkg::PH_IDLE;
              rtu_fte_pkg::PH_WAIT: begin
                phase_next           = rtu_fte_pkg::PH_EMISSION;
                rpt_next.emit_window = 1'b1;
              end
              rtu_fte_pkg::PH_EMISSION: phase_next = rtu_fte_pkg::PH_IDLE;
              default: ;
            endcase
          end
        end
        rtu_fte_pkg::CMD_RX_BYTE: begin
          if (byte_count < FULL) begin
            unique case (phase_reg)
              rtu_fte_pkg::PH_INIT, rtu_fte_pkg::PH_WAIT: begin
                // line not yet quiet: start the long gap again
                long_op = rtu_fte_pkg::TMR_RESTART;
              end
              rtu_fte_pkg::PH_IDLE: begin
                rpt_next.store_en    = 1'b1;
                rpt_next.store_index = 8'(byte_count);
                rpt_next.store_data  = evt.rx_data;
                byte_count_next      = byte_count + BC_W'(1);
                short_op             = rtu_fte_pkg::TMR_RESTART;
                long_op              = rtu_fte_pkg::TMR_RESTART;
                phase_next           = rtu_fte_pkg::PH_RECEPTION;
              end
              rtu_fte_pkg::PH_RECEPTION: begin
                rpt_next.store_en    = 1'b1;
                rpt_next.store_index = 8'(byte_count);
                rpt_next.store_data  = evt.rx_data;
                byte_count_next      = byte_count + BC_W'(1);
                short_op             = rtu_fte_pkg::TMR_CLEAR;
                long_op              = rtu_fte_pkg::TMR_CLEAR;
              end
              default: ;
            endcase
          end else begin
            // buffer full: the frame is thrown away
            short_op               = rtu_fte_pkg::TMR_STOP;
            long_op                = rtu_fte_pkg::TMR_STOP;
            byte_count_next        = '0;
            phase_next             = rtu_fte_pkg::PH_IDLE;
            rpt_next.overflow_drop = 1'b1;
          end
        end
        rtu_fte_pkg::CMD_OVERRUN: begin
          short_op               = rtu_fte_pkg::TMR_STOP;
          long_op                = rtu_fte_pkg::TMR_STOP;
          byte_count_next        = '0;
          phase_next             = rtu_fte_pkg::PH_IDLE;
          rpt_next.overflow_drop = 1'b1;
        end
        rtu_fte_pkg::CMD_CONSUMED: byte_count_next = '0;
        rtu_fte_pkg::CMD_REPLY: begin
          if (phase_reg == rtu_fte_pkg::PH_EMISSION) begin
            if (evt.reply_ok) begin
              rpt_next.tx_start = 1'b1;
            end else begin
              phase_next = rtu_fte_pkg::PH_IDLE;
            end
          end
        end
        rtu_fte_pkg::CMD_TX_DONE: begin
          // quiet period after the reply
          if (phase_reg == rtu_fte_pkg::PH_EMISSION) begin
            long_op = rtu_fte_pkg::TMR_RESTART;
          end
        end
        default: ;
      endcase
    end

    rpt_next.phase        = phase_next;
    rpt_next.frame_length = 9'(byte_count_next);
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg  <= rtu_fte_pkg::PH_INIT;
      byte_count <= '0;
      rpt_valid  <= 1'b0;
    end else begin
      phase_reg  <= phase_next;
      byte_count <= byte_count_next;
      if (evt_take) begin
        rpt_valid <= 1'b1;
      end else if (rpt_ready) begin
        rpt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_take) begin
      rpt <= rpt_next;
    end
  end

  // checks
  a_overrun_drops: assert property (@(posedge clk) disable iff (rst)
    evt_take && evt.cmd == rtu_fte_pkg::CMD_OVERRUN |=>
      rpt_valid && rpt.overflow_drop && rpt.phase == rtu_fte_pkg::PH_IDLE)
    else $error("overrun did not drop the frame");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |-> rpt.frame_length <= 9'(FRAME_BYTES))
    else $error("frame length beyond buffer");

  a_store_in_reception: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && rpt.store_en |->
      !rpt.overflow_drop && rpt.phase == rtu_fte_pkg::PH_RECEPTION)
    else $error("byte stored outside reception");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rpt_valid |-> evt_ready)
    else $error("event stalled with empty output register");

endmodule
